// ----- sv/hjbp_pkg.sv -----
`default_nettype none

package hjbp_pkg;

	// default geometry of the index
	localparam int DEF_BUCKETS      = 64;
	localparam int DEF_BUCKET_DEPTH = 16;

	// field widths
	localparam int MODE_W     = 2;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 31;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 128;

	// request kinds
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

endpackage

`default_nettype wire

// ----- sv/hash_join_build_probe_core.sv -----
`default_nettype none

// Hash join build/probe engine over a bucketed index. A request on s_axis carries a kind in
// tuser (clear, insert, probe; the unused kind is dropped without a result) and a tuple
// (key, value) in tdata. Insert appends the tuple to bucket value mod BUCKETS or reports the
// bucket full; probe walks its bucket in insertion order and returns one match result per
// equal value, the final one marked with tlast, or a single no-match result; clear empties
// every bucket. One request is handled at a time and s_axis_tready is low meanwhile.
// Steps of a request: the bucket number is the low bits of the value when BUCKETS is a
// power of two, and otherwise a multiply by the reciprocal of BUCKETS, then the remainder.
// After that, the fill count of the bucket is read; then insert appends or reports full,
// a probe of an empty bucket gives its no-match result, and any other probe reads and
// compares each stored entry of the bucket in turn (one entry memory read and one compare
// each) before its final result. Clear sweeps the fill table one bucket per cycle and then
// gives its result.
// The same sweep runs after reset: no request is accepted until it has finished.
// Results wait in an output register, and stall the walk only when it is still full.
module hash_join_build_probe_core #(
	parameter int BUCKETS      = hjbp_pkg::DEF_BUCKETS,
	parameter int BUCKET_DEPTH = hjbp_pkg::DEF_BUCKET_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	input  wire logic [hjbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // item_key, item_val, pad
	input  wire logic [hjbp_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
	// result channel
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output      logic [hjbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // right_key, right_val,
	                                                             // left_key, left_val, pad
	output      logic [hjbp_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
	output      logic                             m_axis_tlast   // last
);

	localparam int KW    = hjbp_pkg::KEY_W;
	localparam int VW    = hjbp_pkg::VAL_W;
	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW    = $clog2(BUCKET_DEPTH + 1);
	localparam int ENTS  = BUCKETS * BUCKET_DEPTH;
	localparam int AW    = (ENTS > 1) ? $clog2(ENTS) : 1;
	localparam bit POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
	// rounded-up reciprocal: (value * RECIP_M) >> (VW + BKT_W) is value / BUCKETS
	localparam logic [VW:0] RECIP_M = (VW + 1)'((((64'd1 << (VW + BKT_W)) + 64'(BUCKETS))
	                                            - 64'd1) / 64'(BUCKETS));

	// sequencer states
	localparam logic [3:0] S_CLR  = 4'd0;  // fill table sweep
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_MOD  = 4'd2;  // reciprocal multiply
	localparam logic [3:0] S_FRD  = 4'd3;  // fill count read
	localparam logic [3:0] S_DISP = 4'd4;  // insert, or start of probe
	localparam logic [3:0] S_RD   = 4'd5;  // entry read
	localparam logic [3:0] S_CMP  = 4'd6;  // entry compare
	localparam logic [3:0] S_FIN  = 4'd7;  // final probe result
	localparam logic [3:0] S_CLRO = 4'd8;  // clear result
	localparam logic [3:0] S_REM  = 4'd9;  // bucket remainder

	logic [3:0]                    state_q;
	logic [hjbp_pkg::MODE_W-1:0]   mode_q;
	logic [KW-1:0]                 key_q;
	logic [VW-1:0]                 val_q;
	logic [BKT_W-1:0]              bucket_q;
	logic [BKT_W-1:0]              clr_idx_q;
	logic                          clr_rsp_q;
	logic [2*VW:0]                 prod_q;
	logic [AW-1:0]                 base_q;
	logic [FW-1:0]                 fill_q;
	logic [FW-1:0]                 idx_q;
	logic                          have_q;
	logic [KW-1:0]                 pend_key_q;
	logic [VW-1:0]                 pend_val_q;
	logic [KW+VW-1:0]              ent_q;

	// storage
	logic [KW+VW-1:0]              entry_mem [ENTS];
	logic [FW-1:0]                 fill_mem  [BUCKETS];

	// output register
	logic                          m_valid_q;
	logic [hjbp_pkg::STATUS_W-1:0] o_status_q;
	logic [KW-1:0]                 o_rk_q;
	logic [VW-1:0]                 o_rv_q;
	logic [KW-1:0]                 o_lk_q;
	logic [VW-1:0]                 o_lv_q;
	logic                          o_last_q;

	logic                          s_fire;
	logic                          out_free;
	logic [VW-1:0]                 in_val;
	logic [BKT_W-1:0]              in_bucket;
	logic [BKT_W-1:0]              quo_lo;
	logic [BKT_W-1:0]              quo_mul;
	logic [BKT_W-1:0]              mod_next;
	logic                          bkt_full;
	logic                          ent_match;
	logic                          cmp_go;
	logic                          scan_end;
	logic                          ins_wr;
	logic                          ld_out;
	logic [hjbp_pkg::STATUS_W-1:0] res_status;
	logic [KW-1:0]                 res_rk;
	logic [VW-1:0]                 res_rv;
	logic [KW-1:0]                 res_lk;
	logic [VW-1:0]                 res_lv;
	logic                          res_last;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign in_val        = s_axis_tdata[KW +: VW];

	// power-of-two bucket count: low bits of the value
	assign in_bucket = BKT_W'(in_val & VW'(BUCKETS - 1));

	// other bucket counts: the remainder only needs the low bits of quotient times BUCKETS
	assign quo_lo   = prod_q[VW + BKT_W +: BKT_W];
	assign quo_mul  = quo_lo * BKT_W'(BUCKETS);
	assign mod_next = val_q[BKT_W-1:0] - quo_mul;

	assign bkt_full  = (fill_q == FW'(BUCKET_DEPTH));
	assign ent_match = (ent_q[KW +: VW] == val_q);
	assign cmp_go    = !ent_match || !have_q || out_free;
	assign scan_end  = (FW'(idx_q + FW'(1)) == fill_q);
	assign ins_wr    = (state_q == S_DISP) && (mode_q == hjbp_pkg::MODE_INSERT)
	                   && !bkt_full && out_free;

	// result selection
	always_comb begin
		ld_out     = 1'b0;
		res_status = hjbp_pkg::ST_INSERTED;
		res_rk     = key_q;
		res_rv     = val_q;
		res_lk     = '0;
		res_lv     = '0;
		res_last   = 1'b1;
		unique case (state_q)
			S_DISP: begin
				if (mode_q == hjbp_pkg::MODE_INSERT) begin
					ld_out     = out_free;
					res_status = bkt_full ? hjbp_pkg::ST_FULL : hjbp_pkg::ST_INSERTED;
				end else begin
					ld_out     = out_free && (fill_q == '0);
					res_status = hjbp_pkg::ST_NOMATCH;
					res_rk     = '0;
					res_rv     = '0;
					res_lk     = key_q;
					res_lv     = val_q;
				end
			end
			S_CMP: begin
				ld_out     = ent_match && have_q && out_free;
				res_status = hjbp_pkg::ST_MATCH;
				res_rk     = pend_key_q;
				res_rv     = pend_val_q;
				res_lk     = key_q;
				res_lv     = val_q;
				res_last   = 1'b0;
			end
			S_FIN: begin
				ld_out = out_free;
				res_lk = key_q;
				res_lv = val_q;
				if (have_q) begin
					res_status = hjbp_pkg::ST_MATCH;
					res_rk     = pend_key_q;
					res_rv     = pend_val_q;
				end else begin
					res_status = hjbp_pkg::ST_NOMATCH;
					res_rk     = '0;
					res_rv     = '0;
				end
			end
			S_CLRO: begin
				ld_out     = out_free;
				res_status = hjbp_pkg::ST_CLEARED;
				res_rk     = '0;
				res_rv     = '0;
			end
			default: begin
				ld_out = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_idx_q <= '0;
			clr_rsp_q <= 1'b0;
			have_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ld_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + BKT_W'(1);
					if (clr_idx_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= clr_rsp_q ? S_CLRO : S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_fire) begin
						priority if (s_axis_tuser == hjbp_pkg::MODE_CLEAR) begin
							clr_idx_q <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLR;
						end else if (s_axis_tuser == hjbp_pkg::MODE_INSERT ||
						             s_axis_tuser == hjbp_pkg::MODE_PROBE) begin
							state_q <= POW2 ? S_FRD : S_MOD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MOD: begin
					state_q <= S_REM;
				end
				S_REM: begin
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_DISP;
				end
				S_DISP: begin
					have_q <= 1'b0;
					if (mode_q == hjbp_pkg::MODE_INSERT || fill_q == '0) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmp_go) begin
						if (ent_match) begin
							have_q <= 1'b1;
						end
						state_q <= scan_end ? S_FIN : S_RD;
					end
				end
				S_FIN, S_CLRO: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q   <= s_axis_tuser;
			key_q    <= s_axis_tdata[KW-1:0];
			val_q    <= in_val;
			bucket_q <= POW2 ? in_bucket : '0;
		end
		if (state_q == S_MOD) begin
			prod_q <= (2*VW + 1)'(val_q) * (2*VW + 1)'(RECIP_M);
		end
		if (state_q == S_REM) begin
			bucket_q <= mod_next;
		end
		if (state_q == S_FRD) begin
			base_q <= AW'(bucket_q * BUCKET_DEPTH);
		end
		if (state_q == S_DISP) begin
			idx_q <= '0;
		end
		if (state_q == S_CMP && cmp_go) begin
			idx_q <= FW'(idx_q + FW'(1));
			if (ent_match) begin
				pend_key_q <= ent_q[KW-1:0];
				pend_val_q <= ent_q[KW +: VW];
			end
		end
	end

	// fill table: sweep clear, insert update, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_CLR) begin
			fill_mem[clr_idx_q] <= '0;
		end else if (ins_wr) begin
			fill_mem[bucket_q] <= FW'(fill_q + FW'(1));
		end
		if (state_q == S_FRD) begin
			fill_q <= fill_mem[bucket_q];
		end
	end

	// entry memory: append on insert, registered read during the walk
	always_ff @(posedge clk) begin
		if (ins_wr) begin
			entry_mem[AW'(base_q + AW'(fill_q))] <= {val_q, key_q};
		end
		if (state_q == S_RD) begin
			ent_q <= entry_mem[AW'(base_q + AW'(idx_q))];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ld_out) begin
			o_status_q <= res_status;
			o_rk_q     <= res_rk;
			o_rv_q     <= res_rv;
			o_lk_q     <= res_lk;
			o_lv_q     <= res_lv;
			o_last_q   <= res_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, o_lv_q, o_lk_q, o_rv_q, o_rk_q};
	assign m_axis_tuser  = o_status_q;
	assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire
